// ----- hdl/rfb_pkg.sv -----
`timescale 1ns / 1ps

package rfb_pkg;

  localparam int PIXEL_W = 32;
  localparam int COORD_W = 16;
  localparam int DIM_W   = 9;
  localparam int OP_W    = 2;
  localparam int CNT_W   = 32;

  localparam int FRAME_COLS_DEF = 256;
  localparam int FRAME_ROWS_DEF = 256;

  localparam int IN_DATA_W  = 6 * COORD_W + PIXEL_W;
  localparam int OUT_DATA_W = PIXEL_W + 2 * CNT_W;

  localparam logic [OP_W-1:0] CMD_NOP  = 2'd0;
  localparam logic [OP_W-1:0] CMD_FILL = 2'd1;
  localparam logic [OP_W-1:0] CMD_BLIT = 2'd2;
  localparam logic [OP_W-1:0] CMD_READ = 2'd3;

  localparam logic OUTCOME_DONE     = 1'b0;
  localparam logic OUTCOME_REJECTED = 1'b1;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] ACTIVE_DIM_RST = 9'd256;

endpackage

// ----- hdl/rfb_frame_store.sv -----
`timescale 1ns / 1ps

module rfb_frame_store #(
  parameter int ADDR_W = 16,
  parameter int DEPTH  = 65536
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [rfb_pkg::PIXEL_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [rfb_pkg::PIXEL_W-1:0] rd_data
);

  logic [rfb_pkg::PIXEL_W-1:0] mem [0:DEPTH-1];
  logic [rfb_pkg::PIXEL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/rect_fill_blit_engine.sv -----
`timescale 1ns / 1ps
// 2D fill / blit engine over an on-chip frame store of 32-bit pixels.
// in_*  : one command item. in_tuser = op (nop, fill, blit, read pixel);
//         in_tdata = dest_x, dest_y, rect_w, rect_h, source_x, source_y,
//         fill_color from the lowest bit up.
// out_* : one result item per command. out_tuser = outcome (1 = rejected);
//         out_tdata = read_pixel, fills_done, blits_done.
// cfg_* : write active_width (index 0) or active_height (index 1), only while
//         the engine is idle. Both reset to 256 and are clipped to the frame.
// One command at a time; in_tready is high only while idle. Pixel traffic
// uses one frame store access a cycle. After an accept the engine steps
// through these states before it returns to idle and loads the result:
//   no-op / rejected : S_CHECK, S_DONE
//   read pixel       : S_CHECK, S_RDREQ, S_RDDATA, S_DONE
//   fill             : S_CHECK, S_CLIPH, S_PIX per clipped pixel, S_DONE
//   blit             : S_CHECK, S_CLIPH, S_PIX and S_COPY per copied pixel,
//                      S_PIX alone where the source is outside, S_DONE
// The result sits in an output register; a new command is accepted while it
// waits. If the receiver stalls, a finished command holds until the register
// frees. Reset clears control state and the counters; the frame store holds
// no defined value until written.
module rect_fill_blit_engine #(
  parameter int FRAME_COLS = rfb_pkg::FRAME_COLS_DEF,
  parameter int FRAME_ROWS = rfb_pkg::FRAME_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // dest_x, dest_y, rect_w, rect_h, source_x, source_y, fill_color
  input  logic [rfb_pkg::IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [rfb_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // read_pixel, fills_done, blits_done
  output logic [rfb_pkg::OUT_DATA_W-1:0] out_tdata,
  // outcome
  output logic                           out_tuser,
  input  logic                           cfg_we,
  input  logic [rfb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [rfb_pkg::DIM_W-1:0]      cfg_wdata
);

  localparam int CW     = $clog2(FRAME_COLS);
  localparam int RW     = $clog2(FRAME_ROWS);
  localparam int ADDR_W = RW + CW;
  localparam int DEPTH  = FRAME_ROWS * (1 << CW);
  localparam int DW     = rfb_pkg::DIM_W;
  localparam int XW     = rfb_pkg::COORD_W;
  localparam int PW     = rfb_pkg::PIXEL_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_CLIPH  = 3'd2;
  localparam logic [2:0] S_PIX    = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_RDREQ  = 3'd5;
  localparam logic [2:0] S_RDDATA = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;

  logic [DW-1:0] act_w_r, act_h_r;
  logic [DW-1:0] aw, ah;

  logic [rfb_pkg::OP_W-1:0] op_r;
  logic [XW-1:0] dx_r, dy_r, w_r, h_r, sx_r, sy_r;
  logic [PW-1:0] color_r;

  logic [DW-1:0] wc_r, wc_nxt;
  logic [DW-1:0] k_r, k_nxt, m_r, m_nxt;
  logic [DW-1:0] cols_left_r, cols_left_nxt, rows_left_r, rows_left_nxt;
  logic          rows_back_r, rows_back_nxt, cols_back_r, cols_back_nxt;
  logic          outcome_r, outcome_nxt;
  logic [PW-1:0] pixel_r, pixel_nxt;

  logic [rfb_pkg::CNT_W-1:0] fills_r, fills_nxt, blits_r, blits_nxt;

  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [rfb_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                          out_tuser_r, out_tuser_nxt;

  logic          accept;
  logic          reject;
  logic [XW:0]   x_end, y_end;
  logic [DW-1:0] clip_w, clip_h;
  logic [DW-1:0] drow, dcol;
  logic [XW:0]   srow, scol;
  logic          src_in;
  logic          advance, last_pixel;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [PW-1:0]     wr_data, rd_data;

  // effective active area, never wider than the frame
  assign aw = (int'(act_w_r) < FRAME_COLS) ? act_w_r : DW'(FRAME_COLS);
  assign ah = (int'(act_h_r) < FRAME_ROWS) ? act_h_r : DW'(FRAME_ROWS);

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  assign reject = (dx_r >= XW'(aw)) || (dy_r >= XW'(ah));

  assign x_end  = {1'b0, dx_r} + {1'b0, w_r};
  assign y_end  = {1'b0, dy_r} + {1'b0, h_r};
  assign clip_w = (x_end > (XW+1)'(aw)) ? (aw - dx_r[DW-1:0]) : w_r[DW-1:0];
  assign clip_h = (y_end > (XW+1)'(ah)) ? (ah - dy_r[DW-1:0]) : h_r[DW-1:0];

  assign dcol   = dx_r[DW-1:0] + m_r;
  assign drow   = dy_r[DW-1:0] + k_r;
  assign scol   = {1'b0, sx_r} + (XW+1)'(m_r);
  assign srow   = {1'b0, sy_r} + (XW+1)'(k_r);
  assign src_in = (scol < (XW+1)'(aw)) && (srow < (XW+1)'(ah));

  assign last_pixel = (cols_left_r == DW'(1)) && (rows_left_r == DW'(1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {RW'(drow), CW'(dcol)};
    wr_data = (op_r == rfb_pkg::CMD_FILL) ? color_r : rd_data;
    rd_en   = 1'b0;
    rd_addr = {RW'(srow[DW-1:0]), CW'(scol[DW-1:0])};
    advance = 1'b0;
    unique case (state_r)
      S_PIX: begin
        if (op_r == rfb_pkg::CMD_FILL) begin
          wr_en   = 1'b1;
          advance = 1'b1;
        end else if (src_in) begin
          rd_en = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      S_COPY: begin
        wr_en   = 1'b1;
        advance = 1'b1;
      end
      S_RDREQ: begin
        rd_en   = 1'b1;
        rd_addr = {RW'(dy_r[DW-1:0]), CW'(dx_r[DW-1:0])};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    wc_nxt         = wc_r;
    k_nxt          = k_r;
    m_nxt          = m_r;
    cols_left_nxt  = cols_left_r;
    rows_left_nxt  = rows_left_r;
    rows_back_nxt  = rows_back_r;
    cols_back_nxt  = cols_back_r;
    outcome_nxt    = outcome_r;
    pixel_nxt      = pixel_r;
    fills_nxt      = fills_r;
    blits_nxt      = blits_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        outcome_nxt = rfb_pkg::OUTCOME_DONE;
        pixel_nxt   = '0;
        if (op_r == rfb_pkg::CMD_NOP) begin
          state_nxt = S_DONE;
        end else if (reject) begin
          outcome_nxt = rfb_pkg::OUTCOME_REJECTED;
          state_nxt   = S_DONE;
        end else if (op_r == rfb_pkg::CMD_READ) begin
          state_nxt = S_RDREQ;
        end else begin
          wc_nxt        = clip_w;
          rows_back_nxt = dy_r > sy_r;
          cols_back_nxt = dx_r > sx_r;
          state_nxt     = S_CLIPH;
        end
      end
      S_CLIPH: begin
        k_nxt         = rows_back_r ? clip_h - DW'(1) : '0;
        m_nxt         = cols_back_r ? wc_r - DW'(1) : '0;
        cols_left_nxt = wc_r;
        rows_left_nxt = clip_h;
        if (wc_r == '0 || clip_h == '0) begin
          // empty after clipping: performed and counted, nothing written
          if (op_r == rfb_pkg::CMD_FILL) fills_nxt = fills_r + 1'b1;
          else blits_nxt = blits_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PIX;
        end
      end
      S_PIX, S_COPY: begin
        if (!advance) begin
          state_nxt = S_COPY;
        end else if (last_pixel) begin
          if (op_r == rfb_pkg::CMD_FILL) fills_nxt = fills_r + 1'b1;
          else blits_nxt = blits_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PIX;
          if (cols_left_r == DW'(1)) begin
            cols_left_nxt = wc_r;
            rows_left_nxt = rows_left_r - 1'b1;
            m_nxt         = cols_back_r ? wc_r - DW'(1) : '0;
            k_nxt         = rows_back_r ? k_r - 1'b1 : k_r + 1'b1;
          end else begin
            cols_left_nxt = cols_left_r - 1'b1;
            m_nxt         = cols_back_r ? m_r - 1'b1 : m_r + 1'b1;
          end
        end
      end
      S_RDREQ: begin
        state_nxt = S_RDDATA;
      end
      S_RDDATA: begin
        pixel_nxt = rd_data;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = outcome_r;
          out_tdata_nxt  = {blits_r, fills_r, pixel_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fills_r      <= '0;
      blits_r      <= '0;
      out_tvalid_r <= 1'b0;
      act_w_r      <= rfb_pkg::ACTIVE_DIM_RST;
      act_h_r      <= rfb_pkg::ACTIVE_DIM_RST;
    end else begin
      state_r      <= state_nxt;
      fills_r      <= fills_nxt;
      blits_r      <= blits_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        if (cfg_index == rfb_pkg::REG_ACTIVE_WIDTH) act_w_r <= cfg_wdata;
        if (cfg_index == rfb_pkg::REG_ACTIVE_HEIGHT) act_h_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_tuser;
      dx_r    <= in_tdata[0*XW +: XW];
      dy_r    <= in_tdata[1*XW +: XW];
      w_r     <= in_tdata[2*XW +: XW];
      h_r     <= in_tdata[3*XW +: XW];
      sx_r    <= in_tdata[4*XW +: XW];
      sy_r    <= in_tdata[5*XW +: XW];
      color_r <= in_tdata[6*XW +: PW];
    end
    wc_r        <= wc_nxt;
    k_r         <= k_nxt;
    m_r         <= m_nxt;
    cols_left_r <= cols_left_nxt;
    rows_left_r <= rows_left_nxt;
    rows_back_r <= rows_back_nxt;
    cols_back_r <= cols_back_nxt;
    outcome_r   <= outcome_nxt;
    pixel_r     <= pixel_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  rfb_frame_store #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- hdl/rfb_checker.sv -----
`timescale 1ns / 1ps

module rfb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [rfb_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [rfb_pkg::OP_W-1:0]       in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [rfb_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser,
  input logic                           cfg_we,
  input logic [rfb_pkg::REG_IDX_W-1:0]  cfg_index,
  input logic [rfb_pkg::DIM_W-1:0]      cfg_wdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one command at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while a command is in flight");

  // a rejected command never returns pixel data
  a_reject_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[rfb_pkg::PIXEL_W-1:0] == '0)
    else $error("rejected command carries a pixel value");

  // a new result only comes from a command in flight
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

endmodule

bind rect_fill_blit_engine rfb_checker u_rfb_checker (.*);

// ----- tb/rect_fill_blit_engine_checker.sv -----
`timescale 1ns / 1ps

// Watches the command, result and register ports, keeps a shadow frame store
// and counters, and compares every result item against the predicted one.
module rect_fill_blit_engine_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [rfb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [rfb_pkg::OP_W-1:0]       in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [rfb_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tuser,
  input  logic                           cfg_we,
  input  logic [rfb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [rfb_pkg::DIM_W-1:0]      cfg_wdata,
  output int                             mismatch_count,
  output int                             results_due
);

  localparam int COLS = rfb_pkg::FRAME_COLS_DEF;
  localparam int ROWS = rfb_pkg::FRAME_ROWS_DEF;

  // first field sits in the lowest bits, so it is the last member here
  typedef struct packed {
    logic [rfb_pkg::PIXEL_W-1:0] colour;
    logic [rfb_pkg::COORD_W-1:0] sy;
    logic [rfb_pkg::COORD_W-1:0] sx;
    logic [rfb_pkg::COORD_W-1:0] h;
    logic [rfb_pkg::COORD_W-1:0] w;
    logic [rfb_pkg::COORD_W-1:0] dy;
    logic [rfb_pkg::COORD_W-1:0] dx;
  } command_t;

  typedef struct packed {
    logic                        rejected;
    logic [rfb_pkg::CNT_W-1:0]   blits;
    logic [rfb_pkg::CNT_W-1:0]   fills;
    logic [rfb_pkg::PIXEL_W-1:0] pixel;
  } engine_result_t;

  logic [rfb_pkg::PIXEL_W-1:0] frame_pix [COLS*ROWS];
  logic [rfb_pkg::CNT_W-1:0]   fill_total;
  logic [rfb_pkg::CNT_W-1:0]   blit_total;
  logic [rfb_pkg::DIM_W-1:0]   act_w;
  logic [rfb_pkg::DIM_W-1:0]   act_h;
  engine_result_t              expected_q [$];
  int                          results_seen;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d: %s is %h, expected %h", $time, results_seen, field,
             got, want);
    mismatch_count++;
  endtask

  function automatic engine_result_t execute_command(input logic [rfb_pkg::OP_W-1:0] op,
                                                     input command_t c);
    engine_result_t res;
    int unsigned aw, ah, dx, dy, sx, sy, w, h, i, j, k, m;
    logic rows_back, cols_back;
    res = '0;
    res.rejected = rfb_pkg::OUTCOME_DONE;
    aw = (int'(act_w) < COLS) ? int'(act_w) : COLS;
    ah = (int'(act_h) < ROWS) ? int'(act_h) : ROWS;
    dx = 32'(c.dx);
    dy = 32'(c.dy);
    sx = 32'(c.sx);
    sy = 32'(c.sy);
    w  = 32'(c.w);
    h  = 32'(c.h);
    if (op != rfb_pkg::CMD_NOP) begin
      if (aw == 0 || ah == 0 || dx >= aw || dy >= ah) begin
        res.rejected = rfb_pkg::OUTCOME_REJECTED;
      end else begin
        if (dx + w > aw) w = aw - dx;
        if (dy + h > ah) h = ah - dy;
        case (op)
          rfb_pkg::CMD_FILL: begin
            for (i = 0; i < h; i++)
              for (j = 0; j < w; j++)
                frame_pix[(dy + i) * COLS + dx + j] = c.colour;
            fill_total++;
          end
          rfb_pkg::CMD_BLIT: begin
            // walk backwards along an axis where the destination trails the source
            rows_back = dy > sy;
            cols_back = dx > sx;
            for (i = 0; i < h; i++) begin
              k = rows_back ? (h - 1 - i) : i;
              for (j = 0; j < w; j++) begin
                m = cols_back ? (w - 1 - j) : j;
                if (sx + m < aw && sy + k < ah)
                  frame_pix[(dy + k) * COLS + dx + m] = frame_pix[(sy + k) * COLS + sx + m];
              end
            end
            blit_total++;
          end
          default: res.pixel = frame_pix[dy * COLS + dx];
        endcase
      end
    end
    res.fills = fill_total;
    res.blits = blit_total;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    engine_result_t got, want;
    if (!rst_n) begin
      fill_total = '0;
      blit_total = '0;
      act_w = rfb_pkg::ACTIVE_DIM_RST;
      act_h = rfb_pkg::ACTIVE_DIM_RST;
      mismatch_count = 0;
      results_seen = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rfb_pkg::REG_ACTIVE_WIDTH:  act_w = cfg_wdata;
          rfb_pkg::REG_ACTIVE_HEIGHT: act_h = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(execute_command(in_tuser, command_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        got.rejected = out_tuser;
        {got.blits, got.fills, got.pixel} = out_tdata;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item, outcome", 32'(got.rejected), 'x);
        end else begin
          want = expected_q.pop_front();
          if (got.rejected !== want.rejected)
            report_mismatch("outcome", 32'(got.rejected), 32'(want.rejected));
          if (got.pixel !== want.pixel)
            report_mismatch("read_pixel", got.pixel, want.pixel);
          if (got.fills !== want.fills)
            report_mismatch("fills_done", got.fills, want.fills);
          if (got.blits !== want.blits)
            report_mismatch("blits_done", got.blits, want.blits);
        end
        results_seen++;
      end
    end
    results_due <= expected_q.size();
  end

endmodule

// ----- tb/rect_fill_blit_engine_test.sv -----
`timescale 1ns / 1ps

module rect_fill_blit_engine_test;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  // dest_x, dest_y, rect_w, rect_h, source_x, source_y, fill_color
  logic [rfb_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  // op
  logic [rfb_pkg::OP_W-1:0]       in_tuser   = rfb_pkg::CMD_NOP;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // read_pixel, fills_done, blits_done
  logic [rfb_pkg::OUT_DATA_W-1:0] out_tdata;
  // outcome
  logic                           out_tuser;
  logic                           cfg_we     = 1'b0;
  logic [rfb_pkg::REG_IDX_W-1:0]  cfg_index  = rfb_pkg::REG_ACTIVE_WIDTH;
  logic [rfb_pkg::DIM_W-1:0]      cfg_wdata  = '0;

  int mismatch_count;
  int results_due;

  int unsigned area_w = rfb_pkg::FRAME_COLS_DEF;
  int unsigned area_h = rfb_pkg::FRAME_ROWS_DEF;
  int          burst_left = 0;
  bit          pressure_go = 1'b0;
  bit          pressure_done = 1'b0;

  rect_fill_blit_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  rect_fill_blit_engine_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #(64'd200_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: stretches of always-ready, random, mostly-ready and mostly-stalled
  // behaviour, plus one long hold-off so the engine backs up into its input.
  initial begin : receiver
    int mode;
    int stretch;
    @(posedge clk);
    forever begin
      if (pressure_go && !pressure_done) begin
        out_tready <= 1'b0;
        repeat (4000) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        stretch = $urandom_range(10, 200);
        repeat (stretch) begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            2: out_tready <= ($urandom_range(0, 9) == 0);
            default: out_tready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_cmd(input logic [rfb_pkg::OP_W-1:0] op,
                          input logic [15:0] dx, dy, w, h, sx, sy,
                          input logic [31:0] colour);
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) < 6) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tuser  <= op;
    in_tdata  <= {colour, sy, sx, h, w, dy, dx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic read_px(input logic [15:0] x, y);
    send_cmd(rfb_pkg::CMD_READ, x, y, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
  endtask

  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic set_area(input logic [rfb_pkg::DIM_W-1:0] aw, ah);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_index <= rfb_pkg::REG_ACTIVE_WIDTH;
    cfg_wdata <= aw;
    @(posedge clk);
    cfg_index <= rfb_pkg::REG_ACTIVE_HEIGHT;
    cfg_wdata <= ah;
    @(posedge clk);
    cfg_we <= 1'b0;
    area_w = (int'(aw) > rfb_pkg::FRAME_COLS_DEF) ? rfb_pkg::FRAME_COLS_DEF : int'(aw);
    area_h = (int'(ah) > rfb_pkg::FRAME_ROWS_DEF) ? rfb_pkg::FRAME_ROWS_DEF : int'(ah);
  endtask

  // mostly inside the area, some on the border and some anywhere
  function automatic logic [15:0] pick_coord(input int unsigned lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15 || lim == 0) return 16'($urandom_range(0, 65535));
    if (r < 25) return 16'($urandom_range(0, 1) ? lim - 1 : lim);
    return 16'($urandom_range(0, lim - 1));
  endfunction

  // close to the destination for overlapping copies, else spread out
  function automatic logic [15:0] pick_source(input logic [15:0] d, input int unsigned lim);
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'($urandom_range(0, 65535));
    if (r < 60) begin
      s = int'(d) + int'($urandom_range(0, 8)) - 4;
      return (s < 0) ? 16'd0 : 16'(s);
    end
    return 16'($urandom_range(0, lim + 8));
  endfunction

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(0, 15));
    if (r < 97) return 16'($urandom_range(0, 63));
    return 16'($urandom_range(0, 255));
  endfunction

  task automatic run_random(input int n);
    logic [rfb_pkg::OP_W-1:0] op;
    logic [15:0]              dx, dy, w, h, sx, sy;
    int                       sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      op = (sel < 10) ? rfb_pkg::CMD_NOP :
           (sel < 35) ? rfb_pkg::CMD_FILL :
           (sel < 65) ? rfb_pkg::CMD_BLIT : rfb_pkg::CMD_READ;
      dx = pick_coord(area_w);
      dy = pick_coord(area_h);
      w  = pick_size();
      h  = pick_size();
      // one side at full range now and then; both at once would cost too many cycles
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 1)) w = 16'($urandom);
        else h = 16'($urandom);
      end
      sx = pick_source(dx, area_w);
      sy = pick_source(dy, area_h);
      send_cmd(op, dx, dy, w, h, sx, sy, $urandom);
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // whole frame written first, so no read or blit source is ever unwritten
    send_cmd(rfb_pkg::CMD_FILL, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0,
             32'hA5C3_3C5A);
    read_px(16'd0, 16'd0);
    read_px(16'd255, 16'd255);
    send_cmd(rfb_pkg::CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             32'hFFFF_FFFF);
    send_cmd(rfb_pkg::CMD_FILL, 16'd3, 16'd3, 16'd10, 16'd10, 16'd0, 16'd0, 32'hFFFF_FFFF);
    send_cmd(rfb_pkg::CMD_FILL, 16'd250, 16'd250, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 32'h0);
    // zero-sized rectangles are still performed and counted
    send_cmd(rfb_pkg::CMD_FILL, 16'd10, 16'd10, 16'd0, 16'd5, 16'd0, 16'd0, 32'h1234_5678);
    send_cmd(rfb_pkg::CMD_FILL, 16'd10, 16'd10, 16'd5, 16'd0, 16'd0, 16'd0, 32'h1234_5678);
    send_cmd(rfb_pkg::CMD_BLIT, 16'd30, 16'd30, 16'd0, 16'd0, 16'd1, 16'd1, 32'h0);
    // origin outside the area
    send_cmd(rfb_pkg::CMD_FILL, 16'd256, 16'd0, 16'd4, 16'd4, 16'd0, 16'd0, 32'hDEAD_BEEF);
    send_cmd(rfb_pkg::CMD_FILL, 16'd0, 16'd256, 16'd4, 16'd4, 16'd0, 16'd0, 32'hDEAD_BEEF);
    send_cmd(rfb_pkg::CMD_BLIT, 16'hFFFF, 16'hFFFF, 16'd4, 16'd4, 16'd0, 16'd0, 32'h0);
    read_px(16'd256, 16'd3);
    read_px(16'd3, 16'd256);
    // overlapping copies in each direction
    send_cmd(rfb_pkg::CMD_BLIT, 16'd5, 16'd5, 16'd8, 16'd8, 16'd4, 16'd4, 32'h0);
    send_cmd(rfb_pkg::CMD_BLIT, 16'd4, 16'd4, 16'd8, 16'd8, 16'd5, 16'd5, 32'h0);
    send_cmd(rfb_pkg::CMD_BLIT, 16'd12, 16'd3, 16'd6, 16'd6, 16'd9, 16'd6, 32'h0);
    send_cmd(rfb_pkg::CMD_BLIT, 16'd9, 16'd6, 16'd6, 16'd6, 16'd12, 16'd3, 32'h0);
    // source partly, then wholly, outside the area; then a full-width row copy
    send_cmd(rfb_pkg::CMD_BLIT, 16'd0, 16'd0, 16'd16, 16'd16, 16'd250, 16'd250, 32'h0);
    send_cmd(rfb_pkg::CMD_BLIT, 16'd20, 16'd20, 16'd4, 16'd4, 16'hFFFF, 16'hFFFF, 32'h0);
    send_cmd(rfb_pkg::CMD_BLIT, 16'd0, 16'd100, 16'hFFFF, 16'd2, 16'd0, 16'd101, 32'h0);
    read_px(16'd5, 16'd5);
    read_px(16'd9, 16'd6);
    read_px(16'd251, 16'd251);

    pressure_go = 1'b1;
    run_random(260);
    set_area(9'd511, 9'd511);
    run_random(100);
    set_area(9'd0, 9'd256);
    run_random(30);
    set_area(9'd256, 9'd0);
    run_random(30);
    set_area(9'd1, 9'd1);
    run_random(60);
    set_area(9'd17, 9'd40);
    run_random(120);
    set_area(9'd256, 9'd1);
    run_random(80);
    set_area(9'd1, 9'd256);
    run_random(80);
    repeat (2) begin
      set_area(9'($urandom_range(1, 300)), 9'($urandom_range(1, 300)));
      run_random(100);
    end
    set_area(9'd256, 9'd256);
    run_random(100);

    wait_until_idle();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
